// ===== hw/rtl/led_matrix_scan_refresh_assert.svh =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: assertion macros
// Shorthand for the concurrent checks on the refresh driver ports.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_REFRESH_ASSERT_SVH
`define LED_MATRIX_SCAN_REFRESH_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LMSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lmsr check failed");

// next-cycle implication, disabled in reset
`define LMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lmsr check failed");

`endif

// ===== hw/rtl/lmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: package
// Shared constants, command type and state encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmsr_pkg;

    localparam int SCAN_ROWS_DEF = 16;
    localparam int ROW_BYTES_DEF = 8;
    localparam int CMD_DEPTH     = 2;
    localparam int NUM_RAMS      = 4;
    localparam int CMD_ROW_W     = 5;
    localparam int PIXEL_W       = 8;
    localparam int FRAME_W       = 8;
    localparam int ROW_SEL_W     = 4;
    localparam int PIX_ROW_W     = 5;
    localparam int BYTE_COL_W    = 3;

    localparam logic [7:0] TICK_DIVIDE_RESET = 8'd5;

    // RAM index is {plane, bottom half}
    localparam int RAM_RED_TOP = 0;
    localparam int RAM_RED_BOT = 1;
    localparam int RAM_GRN_TOP = 2;
    localparam int RAM_GRN_BOT = 3;

    typedef struct packed {
        logic [CMD_ROW_W-1:0] row;
        logic [FRAME_W-1:0]   frames_before;
        logic [FRAME_W-1:0]   frames_after;
    } t_cmd;

    typedef enum logic {
        FR_CLEAR,
        FR_RUN
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_SHIFT
    } t_back_state;

endpackage

// ===== hw/rtl/led_matrix_scan_refresh.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh driver
// Two-colour panel refresh with 1/16 scan: red and green framebuffers,
// tick prescaler and row pair shift-out with latch and row select.
//
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------------------------
// request   push / full        action, plane, pixel_row, byte_column,
//                              pixel_byte
// result    empty / pop        four data lines, latch_row, row_select,
//                              frames_shown, last
// config    i_cfg_we           i_cfg_wdata (tick_divide)
//
// The front end holds one request at a time in its input register.
// A refresh loads ROW_BYTES bytes from four framebuffer RAMs, then gives
// ROW_BYTES*8 results at one per cycle while the results are popped.
// Writes stall while a refresh is queued or loading; ticks stall on a full
// command queue only.
// After reset a clearing pass over all SCAN_ROWS*ROW_BYTES addresses (128 by
// default) zeroes the framebuffers; full stays high meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_scan_refresh import lmsr_pkg::*; #(
    parameter int SCAN_ROWS = SCAN_ROWS_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic                  i_plane,
    input  logic [PIX_ROW_W-1:0]  i_pixel_row,
    input  logic [BYTE_COL_W-1:0] i_byte_column,
    input  logic [PIXEL_W-1:0]    i_pixel_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_red_top_level,
    output logic                  o_green_top_level,
    output logic                  o_red_bottom_level,
    output logic                  o_green_bottom_level,
    output logic                  o_latch_row,
    output logic [ROW_SEL_W-1:0]  o_row_select,
    output logic [FRAME_W-1:0]    o_frames_shown,
    output logic                  o_last
);

    localparam int HALF_DEPTH = SCAN_ROWS * ROW_BYTES;
    localparam int AW         = $clog2(HALF_DEPTH);

    logic [NUM_RAMS-1:0] we;
    logic [AW-1:0]       waddr;
    logic [PIXEL_W-1:0]  wdata;
    logic [AW-1:0]       raddr;
    logic [PIXEL_W-1:0]  rd_data [NUM_RAMS];
    logic                cmd_push;
    t_cmd                cmd_in;
    t_cmd                cmd_out;
    logic                cmd_pop;
    logic                cmd_full;
    logic                cmd_empty;
    logic                back_loading;

    lmsr_front #(
        .SCAN_ROWS (SCAN_ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_plane        (i_plane),
        .i_pixel_row    (i_pixel_row),
        .i_byte_column  (i_byte_column),
        .i_pixel_byte   (i_pixel_byte),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .i_cmd_full     (cmd_full),
        .i_cmd_empty    (cmd_empty),
        .i_back_loading (back_loading)
    );

    lmsr_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty),
        .o_full  (cmd_full)
    );

    for (genvar g = 0; g < NUM_RAMS; g++) begin : g_ram
        lmsr_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (HALF_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[g]),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_raddr (raddr),
            .o_rdata (rd_data[g])
        );
    end

    lmsr_back #(
        .SCAN_ROWS (SCAN_ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd_empty          (cmd_empty),
        .i_cmd                (cmd_out),
        .o_cmd_pop            (cmd_pop),
        .o_loading            (back_loading),
        .o_raddr              (raddr),
        .i_rd_data            (rd_data),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_red_top_level      (o_red_top_level),
        .o_green_top_level    (o_green_top_level),
        .o_red_bottom_level   (o_red_bottom_level),
        .o_green_bottom_level (o_green_bottom_level),
        .o_latch_row          (o_latch_row),
        .o_row_select         (o_row_select),
        .o_frames_shown       (o_frames_shown),
        .o_last               (o_last)
    );

endmodule

// ===== hw/rtl/lmsr_ram.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lmsr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: command queue
// Short queue of row refresh commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmsr_cmd_fifo import lmsr_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    always_comb begin
        do_push  = i_push && (r_count != CW'(DEPTH));
        do_pop   = i_pop && (r_count != '0);
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

// ===== hw/rtl/lmsr_front.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: front end
// Clears the framebuffers after reset, takes requests, writes pixel bytes,
// divides ticks and queues row refresh commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmsr_front import lmsr_pkg::*; #(
    parameter int SCAN_ROWS = SCAN_ROWS_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    localparam int HALF_DEPTH = SCAN_ROWS * ROW_BYTES,
    localparam int AW = $clog2(HALF_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_action,
    input  logic                  i_plane,
    input  logic [PIX_ROW_W-1:0]  i_pixel_row,
    input  logic [BYTE_COL_W-1:0] i_byte_column,
    input  logic [PIXEL_W-1:0]    i_pixel_byte,
    output logic [NUM_RAMS-1:0]   o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [PIXEL_W-1:0]    o_wdata,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_full,
    input  logic                  i_cmd_empty,
    input  logic                  i_back_loading
);

    localparam int RW         = $clog2(SCAN_ROWS);
    localparam int FRAME_ROWS = 2 * SCAN_ROWS;

    t_front_state          r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_in_valid, n_in_valid;
    logic                  r_action;
    logic                  r_plane;
    logic [PIX_ROW_W-1:0]  r_pixel_row;
    logic [BYTE_COL_W-1:0] r_byte_column;
    logic [PIXEL_W-1:0]    r_pixel_byte;
    logic [7:0]            r_tick_divide, n_tick_divide;
    logic [7:0]            r_tick_count, n_tick_count;
    logic [RW-1:0]         r_scan_row, n_scan_row;
    logic [FRAME_W-1:0]    r_frame_count, n_frame_count;

    logic                  go;
    logic                  accept;
    logic                  in_range;
    logic                  bottom;
    logic [PIX_ROW_W-1:0]  local_row;
    logic [31:0]           wr_lin;
    logic [7:0]            tick_next;
    logic                  hit;
    logic                  tick_fire;
    logic                  wrap;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_CLEAR: begin
                if (r_clr_addr == AW'(HALF_DEPTH - 1)) begin
                    n_state = FR_RUN;
                end
            end
            FR_RUN: begin
                n_state = FR_RUN;
            end
            default: begin
                n_state = FR_CLEAR;
            end
        endcase
    end

    always_comb begin
        in_range  = (int'(r_pixel_row) < FRAME_ROWS) && (int'(r_byte_column) < ROW_BYTES);
        bottom    = (int'(r_pixel_row) >= SCAN_ROWS);
        local_row = bottom ? (r_pixel_row - PIX_ROW_W'(SCAN_ROWS)) : r_pixel_row;
        wr_lin    = 32'(local_row) * 32'(ROW_BYTES) + 32'(r_byte_column);
        go        = 1'b0;
        o_full    = 1'b1;
        o_we      = '0;
        o_waddr   = wr_lin[AW-1:0];
        o_wdata   = r_pixel_byte;
        case (r_state)
            FR_CLEAR: begin
                o_we    = '1;
                o_waddr = r_clr_addr;
                o_wdata = '0;
            end
            FR_RUN: begin
                go = r_in_valid
                    && (r_action ? !i_cmd_full : (i_cmd_empty && !i_back_loading));
                o_full = r_in_valid && !go;
                if (go && !r_action && in_range) begin
                    o_we[{r_plane, bottom}] = 1'b1;
                end
            end
            default: begin
                o_full = 1'b1;
            end
        endcase
    end

    always_comb begin
        accept     = i_push && !o_full;
        tick_next  = r_tick_count + 8'd1;
        hit        = (tick_next == r_tick_divide);
        tick_fire  = go && r_action;
        wrap       = (r_scan_row == RW'(SCAN_ROWS - 1));
        o_cmd_push = tick_fire && hit;
        o_cmd.row           = CMD_ROW_W'(r_scan_row);
        o_cmd.frames_before = r_frame_count;
        o_cmd.frames_after  = wrap ? r_frame_count + 1'b1 : r_frame_count;

        n_in_valid    = accept ? 1'b1 : (go ? 1'b0 : r_in_valid);
        n_clr_addr    = (r_state == FR_CLEAR) ? r_clr_addr + 1'b1 : r_clr_addr;
        n_tick_divide = i_cfg_we ? i_cfg_wdata : r_tick_divide;
        n_tick_count  = r_tick_count;
        n_scan_row    = r_scan_row;
        n_frame_count = r_frame_count;
        if (tick_fire) begin
            n_tick_count = hit ? 8'd0 : tick_next;
        end
        if (o_cmd_push) begin
            n_scan_row    = wrap ? '0 : r_scan_row + 1'b1;
            n_frame_count = o_cmd.frames_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= FR_CLEAR;
            r_clr_addr    <= '0;
            r_in_valid    <= 1'b0;
            r_tick_divide <= TICK_DIVIDE_RESET;
            r_tick_count  <= '0;
            r_scan_row    <= '0;
            r_frame_count <= '0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_in_valid    <= n_in_valid;
            r_tick_divide <= n_tick_divide;
            r_tick_count  <= n_tick_count;
            r_scan_row    <= n_scan_row;
            r_frame_count <= n_frame_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action      <= i_action;
            r_plane       <= i_plane;
            r_pixel_row   <= i_pixel_row;
            r_byte_column <= i_byte_column;
            r_pixel_byte  <= i_pixel_byte;
        end
    end

endmodule

// ===== hw/rtl/lmsr_back.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: back end
// Loads one row pair from the framebuffers, then shifts it out one pixel
// clock per result, with row select on every result and latch on the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmsr_back import lmsr_pkg::*; #(
    parameter int SCAN_ROWS = SCAN_ROWS_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    localparam int HALF_DEPTH = SCAN_ROWS * ROW_BYTES,
    localparam int AW = $clog2(HALF_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_empty,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_loading,
    output logic [AW-1:0]        o_raddr,
    input  logic [PIXEL_W-1:0]   i_rd_data [NUM_RAMS],
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_red_top_level,
    output logic                 o_green_top_level,
    output logic                 o_red_bottom_level,
    output logic                 o_green_bottom_level,
    output logic                 o_latch_row,
    output logic [ROW_SEL_W-1:0] o_row_select,
    output logic [FRAME_W-1:0]   o_frames_shown,
    output logic                 o_last
);

    localparam int LINE_W = ROW_BYTES * PIXEL_W;
    localparam int LDW    = $clog2(ROW_BYTES + 1);
    localparam int PXW    = $clog2(LINE_W);

    t_back_state          r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [LDW-1:0]       r_ld, n_ld;
    logic [PXW-1:0]       r_pix, n_pix;
    logic [LINE_W-1:0]    r_line [NUM_RAMS];
    logic [LINE_W-1:0]    n_line [NUM_RAMS];
    logic                 r_out_valid, n_out_valid;
    logic [NUM_RAMS-1:0]  r_dat, n_dat;
    logic                 r_fin, n_fin;
    logic [ROW_SEL_W-1:0] r_row_sel, n_row_sel;
    logic [FRAME_W-1:0]   r_frames, n_frames;

    logic                 ld_done;
    logic                 fin;
    logic                 emit;
    logic [31:0]          rd_lin;

    always_comb begin
        ld_done = (r_ld == LDW'(ROW_BYTES));
        fin     = (r_pix == PXW'(LINE_W - 1));
        emit    = (r_state == BK_SHIFT) && (!r_out_valid || i_pop);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: begin
                if (ld_done) begin
                    n_state = BK_SHIFT;
                end
            end
            BK_SHIFT: begin
                if (emit && fin) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        o_loading = 1'b0;
        rd_lin    = 32'(r_cmd.row) * 32'(ROW_BYTES) + 32'(r_ld);
        o_raddr   = rd_lin[AW-1:0];
        case (r_state)
            BK_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
            end
            BK_LOAD: begin
                o_loading = 1'b1;
            end
            BK_SHIFT: begin
                o_loading = 1'b0;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cmd       = o_cmd_pop ? i_cmd : r_cmd;
        n_ld        = r_ld;
        n_pix       = r_pix;
        n_out_valid = emit ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
        n_dat       = r_dat;
        n_fin       = r_fin;
        n_row_sel   = r_row_sel;
        n_frames    = r_frames;
        for (int i = 0; i < NUM_RAMS; i++) begin
            n_line[i] = r_line[i];
        end
        if (o_cmd_pop) begin
            n_ld  = '0;
            n_pix = '0;
        end
        if (r_state == BK_LOAD) begin
            n_ld = r_ld + 1'b1;
            if (r_ld != '0) begin
                for (int i = 0; i < NUM_RAMS; i++) begin
                    n_line[i] = (r_line[i] << PIXEL_W) | LINE_W'(i_rd_data[i]);
                end
            end
        end
        if (emit) begin
            n_pix     = fin ? '0 : r_pix + 1'b1;
            for (int i = 0; i < NUM_RAMS; i++) begin
                n_line[i] = r_line[i] << 1;
                n_dat[i]  = ~r_line[i][LINE_W-1];
            end
            n_fin     = fin;
            n_row_sel = ROW_SEL_W'(r_cmd.row);
            n_frames  = fin ? r_cmd.frames_after : r_cmd.frames_before;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_ld        <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ld        <= n_ld;
            r_pix       <= n_pix;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_dat     <= n_dat;
        r_fin     <= n_fin;
        r_row_sel <= n_row_sel;
        r_frames  <= n_frames;
        for (int i = 0; i < NUM_RAMS; i++) begin
            r_line[i] <= n_line[i];
        end
    end

    assign o_empty              = !r_out_valid;
    assign o_red_top_level      = r_dat[RAM_RED_TOP];
    assign o_green_top_level    = r_dat[RAM_GRN_TOP];
    assign o_red_bottom_level   = r_dat[RAM_RED_BOT];
    assign o_green_bottom_level = r_dat[RAM_GRN_BOT];
    assign o_latch_row          = r_fin;
    assign o_last               = r_fin;
    assign o_row_select         = r_row_sel;
    assign o_frames_shown       = r_frames;

endmodule

// ===== hw/rtl/lmsr_checker.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan refresh: port checker
// Watches the result port of the refresh driver over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_matrix_scan_refresh_assert.svh"

module lmsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_red_top_level,
    input logic       o_green_top_level,
    input logic       o_red_bottom_level,
    input logic       o_green_bottom_level,
    input logic       o_latch_row,
    input logic [3:0] o_row_select,
    input logic [7:0] o_frames_shown,
    input logic       o_last
);

    `LMSR_ASSERT_NOW(a_latch_on_last, i_clk, i_rst_n, !empty, o_latch_row == o_last)

    `LMSR_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_row_select) && $stable(o_frames_shown) && $stable(o_last) && $stable(o_red_top_level) && $stable(o_green_top_level) && $stable(o_red_bottom_level) && $stable(o_green_bottom_level))

    `LMSR_ASSERT_NEXT(a_row_steady, i_clk, i_rst_n, !empty && pop && !o_last, empty || o_row_select == $past(o_row_select))

endmodule

bind led_matrix_scan_refresh lmsr_checker u_lmsr_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .empty                (empty),
    .pop                  (pop),
    .o_red_top_level      (o_red_top_level),
    .o_green_top_level    (o_green_top_level),
    .o_red_bottom_level   (o_red_bottom_level),
    .o_green_bottom_level (o_green_bottom_level),
    .o_latch_row          (o_latch_row),
    .o_row_select         (o_row_select),
    .o_frames_shown       (o_frames_shown),
    .o_last               (o_last)
);
